// ===== rtl/core/mfr_pkg.sv =====
// Package for the mixed fraction reducer: widths, status codes and the
// control struct that runs between the sequencer and the serial divider.
`timescale 1ns / 1ps
`default_nettype none
package mfr_pkg;
	localparam int unsigned WIDTH = 32;
	localparam int unsigned DEN_W = 31;
	localparam int unsigned MAG_W = 33;
	localparam int unsigned TOT_W = 64;
	localparam int unsigned CNT_W = $clog2(TOT_W + 1);

	typedef enum logic [0:0] {
		ST_OK       = 1'b0,
		ST_ZERO_DEN = 1'b1
	} status_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/mfr_if.sv =====
// Valid/ready channel interfaces for the mixed fraction reducer.
// Depends on mfr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface mfr_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] whole_part;
	logic signed [31:0] numer_in;
	logic [mfr_pkg::DEN_W-1:0] denom_in;
	modport source (output valid, whole_part, numer_in, denom_in, input ready);
	modport sink (input valid, whole_part, numer_in, denom_in, output ready);
endinterface

interface mfr_out_if;
	logic valid;
	logic ready;
	logic is_negative;
	logic [mfr_pkg::WIDTH-1:0] whole_mag;
	logic [mfr_pkg::DEN_W-1:0] numer_out;
	logic [mfr_pkg::DEN_W-1:0] denom_out;
	logic status;
	modport source (output valid, is_negative, whole_mag, numer_out, denom_out, status,
		input ready);
	modport sink (input valid, is_negative, whole_mag, numer_out, denom_out, status,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mixed_fraction_reducer.sv =====
// Mixed fraction reducer: one word in, one reduced word out, sequenced
// over a bit-serial multiplier and divider. Depends on mfr_pkg, mfr_if.
//
// Rate: one word at a time. The multiply runs from acceptance through an
// issue step, a load step and the 31 multiplier-bit steps. Every divide runs
// from issue to the next issue through a load, 64 quotient-bit steps and a
// step to see done. A word needs the split divide, one divide per
// Euclid step (none when the remainder is zero, at most about 46) and the
// two reducing divides. The time per word is set almost
// entirely by the one 64-step serial divider, which is reused for every
// step. A zero denominator is answered on the cycle after the word is
// taken. The result sits in an output register. The next word is taken in
// the cycle after that result has been delivered.
`timescale 1ns / 1ps
`default_nettype none
module mixed_fraction_reducer (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mfr_in_if.sink     in_ch,
	mfr_out_if.source  out_ch
);
	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_SPLIT, S_GCD, S_RNUM, S_RDEN, S_OUT
	} state_t;

	state_t state_q;
	logic neg_q;
	logic [mfr_pkg::MAG_W-1:0] wmag_q, nmag_q;
	logic [mfr_pkg::DEN_W-1:0] den_q, rem_q, gb_q;
	logic [mfr_pkg::WIDTH-1:0] whole_q;
	logic mul_start_q, mul_done;
	logic [mfr_pkg::TOT_W-1:0] prod;
	mfr_pkg::div_ctl_t dctl_q, dctl_out;
	logic [mfr_pkg::TOT_W-1:0] div_a_q, quot;
	logic [mfr_pkg::DEN_W-1:0] div_b_q, drem;
	logic [mfr_pkg::TOT_W-1:0] lim;
	logic [mfr_pkg::MAG_W-1:0] wm_in, nm_in;

	assign lim = (mfr_pkg::TOT_W'(1) << mfr_pkg::WIDTH) - 1'b1;
	assign wm_in = in_ch.whole_part[31] ? (33'h1_0000_0000 - {1'b0, in_ch.whole_part})
		: {1'b0, in_ch.whole_part};
	assign nm_in = in_ch.numer_in[31] ? (33'h1_0000_0000 - {1'b0, in_ch.numer_in})
		: {1'b0, in_ch.numer_in};

	assign in_ch.ready = (state_q == S_IDLE);

	mfr_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q), .a(wmag_q), .b(den_q),
		.done(mul_done), .prod(prod)
	);

	mfr_div u_div (
		.clk(clk), .arst_n(arst_n), .ctl_in(dctl_q), .dividend(div_a_q), .divisor(div_b_q),
		.ctl_out(dctl_out), .quot(quot), .rem(drem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_ch.valid <= 1'b0;
			out_ch.is_negative <= 1'b0;
			out_ch.whole_mag <= '0;
			out_ch.numer_out <= '0;
			out_ch.denom_out <= '0;
			out_ch.status <= mfr_pkg::ST_OK;
			mul_start_q <= 1'b0;
			dctl_q <= '0;
			neg_q <= 1'b0;
			wmag_q <= '0;
			nmag_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			gb_q <= '0;
			whole_q <= '0;
			div_a_q <= '0;
			div_b_q <= '0;
		end else begin
			mul_start_q <= 1'b0;
			dctl_q <= '0;
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						if (in_ch.denom_in == '0) begin
							out_ch.is_negative <= 1'b0;
							out_ch.whole_mag <= '0;
							out_ch.numer_out <= '0;
							out_ch.denom_out <= '0;
							out_ch.status <= mfr_pkg::ST_ZERO_DEN;
							out_ch.valid <= 1'b1;
							state_q <= S_OUT;
						end else begin
							neg_q <= in_ch.whole_part[31] | in_ch.numer_in[31];
							wmag_q <= wm_in;
							nmag_q <= nm_in;
							den_q <= in_ch.denom_in;
							mul_start_q <= 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					if (mul_done) begin
						// numerator magnitude may be 2^31; add it at full width
						div_a_q <= prod + mfr_pkg::TOT_W'(nmag_q);
						div_b_q <= den_q;
						dctl_q.start <= 1'b1;
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					if (dctl_out.done) begin
						whole_q <= (quot > lim) ? lim[mfr_pkg::WIDTH-1:0]
							: quot[mfr_pkg::WIDTH-1:0];
						rem_q <= drem;
						gb_q <= drem;
						if (drem == '0) begin
							div_a_q <= '0;
							div_b_q <= den_q;
							dctl_q.start <= 1'b1;
							state_q <= S_RNUM;
						end else begin
							div_a_q <= mfr_pkg::TOT_W'(den_q);
							div_b_q <= drem;
							dctl_q.start <= 1'b1;
							state_q <= S_GCD;
						end
					end
				end
				S_GCD: begin
					if (dctl_out.done) begin
						gb_q <= drem;
						if (drem == '0) begin
							div_a_q <= mfr_pkg::TOT_W'(rem_q);
							div_b_q <= gb_q;
							dctl_q.start <= 1'b1;
							state_q <= S_RNUM;
						end else begin
							div_a_q <= mfr_pkg::TOT_W'(gb_q);
							div_b_q <= drem;
							dctl_q.start <= 1'b1;
						end
					end
				end
				S_RNUM: begin
					if (dctl_out.done) begin
						out_ch.numer_out <= quot[mfr_pkg::DEN_W-1:0];
						div_a_q <= mfr_pkg::TOT_W'(den_q);
						dctl_q.start <= 1'b1;
						state_q <= S_RDEN;
					end
				end
				S_RDEN: begin
					if (dctl_out.done) begin
						out_ch.denom_out <= quot[mfr_pkg::DEN_W-1:0];
						out_ch.is_negative <= neg_q;
						out_ch.whole_mag <= whole_q;
						out_ch.status <= mfr_pkg::ST_OK;
						out_ch.valid <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/mfr_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle: 33 x 31 bits.
// Depends on mfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfr_mul (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [mfr_pkg::MAG_W-1:0]     a,
	input  wire logic [mfr_pkg::DEN_W-1:0]     b,
	output logic                               done,
	output logic [mfr_pkg::TOT_W-1:0]          prod
);
	logic [mfr_pkg::TOT_W-1:0] acc_q;
	logic [mfr_pkg::TOT_W-1:0] mcand_q;
	logic [mfr_pkg::DEN_W-1:0] mplier_q;
	logic [mfr_pkg::CNT_W-1:0] cnt_q;
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= mfr_pkg::CNT_W'(mfr_pkg::DEN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == mfr_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mcand_q <= mfr_pkg::TOT_W'(a);
			mplier_q <= b;
		end else if (busy_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q <= {mcand_q[mfr_pkg::TOT_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[mfr_pkg::DEN_W-1:1]};
		end
	end

	assign prod = acc_q;
endmodule
`default_nettype wire

// ===== rtl/core/mfr_div.sv =====
// Restoring divider, one quotient bit per cycle: 64-bit dividend by a
// 31-bit divisor. Depends on mfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfr_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mfr_pkg::div_ctl_t             ctl_in,
	input  wire logic [mfr_pkg::TOT_W-1:0]     dividend,
	input  wire logic [mfr_pkg::DEN_W-1:0]     divisor,
	output mfr_pkg::div_ctl_t                  ctl_out,
	output logic [mfr_pkg::TOT_W-1:0]          quot,
	output logic [mfr_pkg::DEN_W-1:0]          rem
);
	logic [mfr_pkg::TOT_W-1:0] quo_q;
	logic [mfr_pkg::DEN_W:0] rem_q;
	logic [mfr_pkg::DEN_W-1:0] dsr_q;
	logic [mfr_pkg::CNT_W-1:0] cnt_q;
	logic busy_q;
	logic [mfr_pkg::DEN_W:0] trial;
	logic [mfr_pkg::DEN_W+1:0] diff;

	assign trial = {rem_q[mfr_pkg::DEN_W-1:0], quo_q[mfr_pkg::TOT_W-1]};
	assign diff = {1'b0, trial} - {2'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ctl_out <= '0;
			cnt_q <= '0;
		end else begin
			ctl_out <= '0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				cnt_q <= mfr_pkg::CNT_W'(mfr_pkg::TOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == mfr_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					ctl_out.done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[mfr_pkg::DEN_W+1]) begin
				rem_q <= diff[mfr_pkg::DEN_W:0];
				quo_q <= {quo_q[mfr_pkg::TOT_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[mfr_pkg::TOT_W-2:0], 1'b0};
			end
		end
	end

	assign quot = quo_q;
	assign rem = rem_q[mfr_pkg::DEN_W-1:0];
endmodule
`default_nettype wire
